FILE: sv/lpfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by every module of the block.
package lpfd_pkg;

  localparam int TAG_BYTES    = 16;
  localparam int HEADER_BYTES = 4;

  localparam logic [7:0] FTYPE_CRYPTO = 8'd0;
  localparam logic [7:0] FTYPE_STREAM = 8'd1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TAG     = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KEY  = 2'd1;
  localparam logic [1:0] ERR_TYPE = 2'd2;

  localparam logic [16:0] TAG_LEN   = 17'(TAG_BYTES);
  localparam logic [2:0]  HDR_COUNT = 3'(HEADER_BYTES);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } lpfd_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic [7:0]  key_kind;
    logic [7:0]  frame_kind;
    logic [15:0] payload_length;
    logic        frame_end;
    logic [1:0]  error_code;
    logic        chunk_done;
  } lpfd_result_t;

  typedef struct packed {
    logic [2:0] header_count;
    logic [1:0] error_code;
  } lpfd_status_t;

endpackage

FILE: sv/lpfd_in_stage.sv
`timescale 1ns / 1ps
// Input register of the deframer: holds one stream beat for the parser.
// Depends on lpfd_pkg.
module lpfd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpfd_pkg::lpfd_beat_t in_beat,
  input  logic               advance,
  output logic               beat_valid,
  output lpfd_pkg::lpfd_beat_t beat
);
  import lpfd_pkg::*;

  logic       valid_r;
  lpfd_beat_t beat_r;

  assign in_ready   = !valid_r || advance;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

FILE: sv/lpfd_parser.sv
`timescale 1ns / 1ps
// Frame parser: header capture, header check, payload/tag countdown, sticky error.
// Depends on lpfd_pkg.
module lpfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lpfd_pkg::lpfd_beat_t beat,
  input  logic [1:0]           read_key_level,
  output lpfd_pkg::lpfd_result_t result,
  output lpfd_pkg::lpfd_status_t status
);
  import lpfd_pkg::*;

  logic [2:0]  hc_r, hc_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [1:0]  kind;
  logic [1:0]  pos;
  logic        frame_end;

  always_comb begin
    hc_nxt    = hc_r;
    key_nxt   = key_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    frame_end = 1'b0;
    kind      = KIND_DROPPED;
    pos       = (hc_r < HDR_COUNT) ? hc_r[1:0] : 2'd0;
    if (err_r != ERR_NONE) begin
      kind = KIND_DROPPED;
    end else if (hc_r < HDR_COUNT || rem_r == 17'd0) begin
      kind = KIND_HEADER;
      case (pos)
        2'd0: begin
          key_nxt  = beat.data_byte;
          type_nxt = 8'd0;
          len_nxt  = 16'd0;
        end
        2'd1: type_nxt = beat.data_byte;
        2'd2: len_nxt  = {len_r[15:8], beat.data_byte};
        default: len_nxt = {beat.data_byte, len_r[7:0]};
      endcase
      hc_nxt = {1'b0, pos} + 3'd1;
      if (pos == 2'd3) begin
        if (key_nxt != 8'd0 && key_nxt > {6'd0, read_key_level}) begin
          err_nxt = ERR_KEY;
        end else if (!(type_nxt inside {FTYPE_CRYPTO, FTYPE_STREAM})) begin
          err_nxt = ERR_TYPE;
        end
        rem_nxt = {1'b0, len_nxt} + TAG_LEN;
        if (err_nxt == ERR_NONE && rem_nxt == 17'd0) begin
          frame_end = 1'b1;
          hc_nxt    = 3'd0;
        end
      end
    end else begin
      kind    = (rem_r > TAG_LEN) ? KIND_PAYLOAD : KIND_TAG;
      rem_nxt = rem_r - 17'd1;
      if (rem_r == 17'd1) begin
        frame_end = 1'b1;
        hc_nxt    = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r   <= 3'd0;
      key_r  <= 8'd0;
      type_r <= 8'd0;
      len_r  <= 16'd0;
      rem_r  <= 17'd0;
      err_r  <= ERR_NONE;
    end else if (step) begin
      hc_r   <= hc_nxt;
      key_r  <= key_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      rem_r  <= rem_nxt;
      err_r  <= err_nxt;
    end
  end

  assign result.out_byte       = beat.data_byte;
  assign result.byte_kind      = kind;
  assign result.key_kind       = key_nxt;
  assign result.frame_kind     = type_nxt;
  assign result.payload_length = len_nxt;
  assign result.frame_end      = frame_end;
  assign result.error_code     = err_nxt;
  assign result.chunk_done     = beat.chunk_last;

  assign status.header_count = hc_r;
  assign status.error_code   = err_r;

endmodule

FILE: sv/lpfd_out_stage.sv
`timescale 1ns / 1ps
// Result register of the deframer: holds one labelled beat until taken.
// Depends on lpfd_pkg.
module lpfd_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  lpfd_pkg::lpfd_result_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lpfd_pkg::lpfd_result_t out_res
);
  import lpfd_pkg::*;

  logic         valid_r;
  lpfd_result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

FILE: sv/length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_in_stage, lpfd_parser and lpfd_out_stage.
//
// Input channel (in_valid/in_ready): one stream byte per beat, chunk_last
// echoed only. Output channel (out_valid/out_ready): one labelled beat per
// input beat: header, payload, tag or dropped, with the current frame's key
// type, frame type and payload length, a flag on the frame's last byte and
// the sticky error code. Config channel (cfg_valid/cfg_ready) writes the
// read key level; it is always ready. The user must see that it is written
// only while idle; the block itself does not enforce this. An accepted beat
// passes the input register, the combinational parse and the result register.
// Throughput: one beat per cycle while out_ready holds. Reset (synchronous,
// rst_n low) clears the frame state, the error and the key level and empties
// both registers. When the receiver stalls, the result register holds; an
// empty input register still takes one more beat, after which in_ready drops
// until out_ready returns.
module length_prefixed_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic [1:0]  out_byte_kind,
  output logic [7:0]  out_key_kind,
  output logic [7:0]  out_frame_kind,
  output logic [15:0] out_payload_length,
  output logic        out_frame_end,
  output logic [1:0]  out_error_code,
  output logic        out_chunk_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_read_key_level
);
  import lpfd_pkg::*;

  logic [1:0]   level_r;
  lpfd_beat_t   in_beat;
  lpfd_beat_t   beat;
  logic         beat_valid;
  logic         advance;
  logic         step;
  lpfd_result_t res;
  lpfd_result_t out_res;
  lpfd_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      level_r <= cfg_read_key_level;
    end
  end

  assign in_beat.data_byte  = in_data_byte;
  assign in_beat.chunk_last = in_chunk_last;
  assign step               = beat_valid && advance;

  lpfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  lpfd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .beat           (beat),
    .read_key_level (level_r),
    .result         (res),
    .status         (status)
  );

  lpfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (beat_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_out_byte       = out_res.out_byte;
  assign out_byte_kind      = out_res.byte_kind;
  assign out_key_kind       = out_res.key_kind;
  assign out_frame_kind     = out_res.frame_kind;
  assign out_payload_length = out_res.payload_length;
  assign out_frame_end      = out_res.frame_end;
  assign out_error_code     = out_res.error_code;
  assign out_chunk_done     = out_res.chunk_done;

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status.error_code != ERR_NONE) |=> (status.error_code == $past(status.error_code)))
    else $error("sticky error changed");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    status.header_count <= HDR_COUNT)
    else $error("header count out of range");

  a_drop_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_kind == KIND_DROPPED) |-> (out_error_code != ERR_NONE))
    else $error("dropped beat without error");

  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_byte_kind != KIND_DROPPED &&
                                      out_byte_kind != KIND_PAYLOAD))
    else $error("frame end on payload or dropped beat");
`endif

endmodule
